>>> hdl/bipr_pkg.sv
// Shared types and constants for the bulk IN packet ring.
package bipr_pkg;

	localparam int NUM_BUFFERS_DEF  = 16;
	localparam int PACKET_BYTES_DEF = 64;

	typedef enum logic [1:0] {
		FN_BYTE      = 2'd0,
		FN_DONE      = 2'd1,
		FN_READ      = 2'd2,
		FN_BUS_RESET = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BUSY     = 2'd1,
		ST_DETACHED = 2'd2,
		ST_TOO_LONG = 2'd3
	} status_t;

	typedef struct packed {
		func_t      func;
		logic [7:0] data;
		logic       first;
		logic [9:0] msg_len;
		logic       attached;
		logic [3:0] read_index;
		logic [5:0] read_offset;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic       start_valid;
		logic [3:0] start_index;
		logic [5:0] start_length;
		logic [7:0] read_data;
	} rsp_t;

endpackage

>>> hdl/bulk_in_packet_ring.sv
// Bulk IN packet ring: request register, single-pass update logic, result register.
// Each word passes the request register, then its result the result register.
// Throughput: one word per cycle unless the receiver stalls; the ring state and the store
// update as each word leaves the request register, so the next word sees them.
// Reset (arst_n low): lengths, pointers and message state clear; the packet store
// is not cleared and holds undefined bytes until written.
module bulk_in_packet_ring #(
	parameter int NUM_BUFFERS  = bipr_pkg::NUM_BUFFERS_DEF,
	parameter int PACKET_BYTES = bipr_pkg::PACKET_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  bipr_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output bipr_pkg::rsp_t rsp
);
	import bipr_pkg::*;

	localparam int BUF_CAP = PACKET_BYTES - 1;
	localparam int DEPTH   = NUM_BUFFERS * BUF_CAP;
	localparam int BW      = $clog2(NUM_BUFFERS);
	localparam int LW      = $clog2(PACKET_BYTES);
	localparam int AW      = $clog2(DEPTH);
	localparam int CW      = BW + LW + 12;
	localparam int RW      = AW + 4;
	localparam int MAX_LEN = (NUM_BUFFERS - 1) * BUF_CAP;

	// pipeline
	logic         valid_s1;
	req_t         req_s1;
	logic         valid_s2;
	rsp_t         rsp_s2;
	logic         rd_ok_s2;
	logic [7:0]   rd_data_s2;
	logic         adv;

	// ring state
	logic [LW-1:0] fill_q [NUM_BUFFERS];
	logic [BW-1:0] wp_q, sp_q;
	logic          be_q, ref_q;
	logic [9:0]    bl_q;

	logic [LW-1:0] fill_d [NUM_BUFFERS];
	logic [BW-1:0] wp_d, sp_d;
	logic          be_d, ref_d;
	logic [9:0]    bl_d;
	rsp_t          rsp_d;
	logic          rd_ok_d;

	logic          we;
	logic [AW-1:0] wa;
	logic [AW-1:0] ra;
	logic [RW-1:0] ra_full;

	logic [7:0] store [DEPTH];

	assign adv       = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || adv;

	function automatic logic [BW-1:0] nxt(input logic [BW-1:0] i);
		nxt = (i == BW'(NUM_BUFFERS - 1)) ? '0 : i + 1'b1;
	endfunction

	always_comb begin
		logic [BW:0]   d;
		logic [BW:0]   am1;
		logic [BW-1:0] wp1, s2;
		logic [LW-1:0] f1, sfill;
		logic [9:0]    bl0, bl1;
		logic          be0, wrote;

		fill_d  = fill_q;
		wp_d    = wp_q;
		sp_d    = sp_q;
		be_d    = be_q;
		bl_d    = bl_q;
		ref_d   = ref_q;
		rsp_d   = '0;
		rd_ok_d = 1'b0;
		we      = 1'b0;
		wa      = '0;
		wp1     = wp_q;
		f1      = '0;
		s2      = '0;
		sfill   = '0;
		bl0     = bl_q;
		bl1     = '0;
		be0     = be_q;
		wrote   = 1'b0;

		// free buffers counted from the open one up to the head
		if (sp_q >= wp_q)
			d = {1'b0, sp_q} - {1'b0, wp_q};
		else
			d = {1'b0, sp_q} + (BW+1)'(NUM_BUFFERS) - {1'b0, wp_q};
		am1 = (d == '0) ? (BW+1)'(NUM_BUFFERS - 1) : d - 1'b1;

		ra_full = RW'(req_s1.read_index) * RW'(BUF_CAP) + RW'(req_s1.read_offset);
		ra      = ra_full[AW-1:0];

		unique case (req_s1.func)
			FN_BYTE: begin
				if (req_s1.first) begin
					if (bl_q != '0) begin
						rsp_d.status = ST_BUSY;
					end else if (!req_s1.attached) begin
						rsp_d.status = ST_DETACHED;
						ref_d        = 1'b1;
					end else if (req_s1.msg_len == '0 ||
							CW'(req_s1.msg_len) > CW'(MAX_LEN)) begin
						rsp_d.status = ST_TOO_LONG;
						ref_d        = 1'b1;
					end else if (CW'(req_s1.msg_len) > CW'(am1) * CW'(BUF_CAP)) begin
						rsp_d.status = ST_BUSY;
						ref_d        = 1'b1;
					end else begin
						ref_d = 1'b0;
						bl0   = req_s1.msg_len;
						be0   = (wp_q == sp_q);
						we    = 1'b1;
					end
				end else if (bl_q != '0) begin
					we = 1'b1;
				end else begin
					rsp_d.status = ref_q ? ST_BUSY : ST_TOO_LONG;
				end
				// we marks a byte that goes into the open message
				if (we) begin
					wp1 = (fill_q[wp_q] >= LW'(BUF_CAP)) ? nxt(wp_q) : wp_q;
					f1  = fill_q[wp1];
					wrote = (f1 < LW'(BUF_CAP));
					if (wrote)
						fill_d[wp1] = f1 + 1'b1;
					wa  = AW'(wp1) * AW'(BUF_CAP) + AW'(f1);
					bl1 = (bl0 != '0) ? bl0 - 1'b1 : '0;
					wp_d = wp1;
					bl_d = bl1;
					be_d = be0;
					if (bl1 == '0 && be0) begin
						sfill = (sp_q == wp1 && wrote) ? f1 + 1'b1 : fill_q[sp_q];
						wp_d  = nxt(wp1);
						be_d  = 1'b0;
						rsp_d.start_valid  = 1'b1;
						rsp_d.start_index  = 4'(sp_q);
						rsp_d.start_length = 6'(sfill);
					end
					we = wrote;
				end
			end
			FN_DONE: begin
				if (fill_q[sp_q] != '0 && !(bl_q != '0 && be_q)) begin
					s2 = nxt(sp_q);
					fill_d[sp_q] = '0;
					sp_d = s2;
					if (fill_q[s2] != '0) begin
						// the next head may still be the open buffer: close it
						if (wp_q == s2)
							wp_d = nxt(wp_q);
						rsp_d.start_valid  = 1'b1;
						rsp_d.start_index  = 4'(s2);
						rsp_d.start_length = 6'(fill_q[s2]);
					end else if (bl_q != '0) begin
						be_d = 1'b1;
					end
				end
			end
			FN_READ: begin
				rd_ok_d = (32'(req_s1.read_index) < NUM_BUFFERS) &&
					(32'(req_s1.read_offset) < BUF_CAP);
			end
			FN_BUS_RESET: begin
				for (int i = 0; i < NUM_BUFFERS; i++)
					fill_d[i] = '0;
				wp_d  = '0;
				sp_d  = '0;
				be_d  = 1'b0;
				bl_d  = '0;
				ref_d = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			wp_q     <= '0;
			sp_q     <= '0;
			be_q     <= 1'b0;
			bl_q     <= '0;
			ref_q    <= 1'b0;
			for (int i = 0; i < NUM_BUFFERS; i++)
				fill_q[i] <= '0;
		end else begin
			if (req_ready)
				valid_s1 <= req_valid;
			if (adv) begin
				valid_s2 <= 1'b1;
				wp_q     <= wp_d;
				sp_q     <= sp_d;
				be_q     <= be_d;
				bl_q     <= bl_d;
				ref_q    <= ref_d;
				fill_q   <= fill_d;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid)
			req_s1 <= req;
		if (adv) begin
			rsp_s2   <= rsp_d;
			rd_ok_s2 <= rd_ok_d;
		end
	end

	// packet store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (adv && we)
			store[wa] <= req_s1.data;
		if (adv && rd_ok_d)
			rd_data_s2 <= store[ra];
	end

	assign rsp_valid = valid_s2;

	always_comb begin
		rsp           = rsp_s2;
		rsp.read_data = rd_ok_s2 ? rd_data_s2 : 8'd0;
	end

endmodule

>>> dv/testbench.sv
// Testbench for bulk_in_packet_ring: random and directed words, scoreboard with ring predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bipr_pkg::*;

	localparam int NB           = NUM_BUFFERS_DEF;
	localparam int CAP          = PACKET_BYTES_DEF - 1;
	localparam int IDLE_LIMIT   = 1000;
	localparam int RANDOM_WORDS = 1500;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	bulk_in_packet_ring dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	class ring_scoreboard;
		logic [7:0]  store [NB*CAP];
		bit          written [NB*CAP];
		int unsigned fill_len [NB];
		int unsigned wr_ptr;
		int unsigned sd_ptr;
		int unsigned bytes_left;
		bit          began_empty;
		bit          refusing;
		rsp_t        pred;
		rsp_t        pending_rsp [$];
		int          mismatches;

		function int unsigned next_buf(int unsigned i);
			return (i + 1) % NB;
		endfunction

		function void start_head();
			pred.start_valid  = 1'b1;
			pred.start_index  = 4'(sd_ptr);
			pred.start_length = 6'(fill_len[sd_ptr]);
		endfunction

		function void put_byte(logic [7:0] d);
			int unsigned a;
			if (fill_len[wr_ptr] >= CAP)
				wr_ptr = next_buf(wr_ptr);
			if (fill_len[wr_ptr] < CAP) begin
				a = wr_ptr * CAP + fill_len[wr_ptr];
				store[a] = d;
				written[a] = 1'b1;
				fill_len[wr_ptr]++;
			end
			if (bytes_left > 0)
				bytes_left--;
			// message that found the ring idle closes its buffer and kicks a transfer
			if (bytes_left == 0 && began_empty) begin
				wr_ptr = next_buf(wr_ptr);
				start_head();
				began_empty = 1'b0;
			end
		endfunction

		function void note_word(req_t w);
			int unsigned need;
			int unsigned avail;
			pred = '0;
			case (w.func)
				FN_BYTE: begin
					if (w.first) begin
						need = (w.msg_len + CAP - 1) / CAP + 1;
						avail = (sd_ptr + NB - wr_ptr) % NB;
						if (avail == 0)
							avail = NB;
						if (bytes_left > 0) begin
							pred.status = ST_BUSY;
						end else if (!w.attached) begin
							pred.status = ST_DETACHED;
							refusing = 1'b1;
						end else if (w.msg_len == 0 || need > NB) begin
							pred.status = ST_TOO_LONG;
							refusing = 1'b1;
						end else if (need > avail) begin
							pred.status = ST_BUSY;
							refusing = 1'b1;
						end else begin
							refusing = 1'b0;
							bytes_left = w.msg_len;
							began_empty = (wr_ptr == sd_ptr);
							put_byte(w.data);
						end
					end else if (bytes_left > 0) begin
						put_byte(w.data);
					end else begin
						pred.status = refusing ? ST_BUSY : ST_TOO_LONG;
					end
				end
				FN_DONE: begin
					if (fill_len[sd_ptr] != 0 && !(bytes_left > 0 && began_empty)) begin
						fill_len[sd_ptr] = 0;
						sd_ptr = next_buf(sd_ptr);
						if (fill_len[sd_ptr] > 0) begin
							if (wr_ptr == sd_ptr)
								wr_ptr = next_buf(wr_ptr);
							start_head();
						end else if (bytes_left > 0) begin
							began_empty = 1'b1;
						end
					end
				end
				FN_READ: begin
					if (w.read_offset < CAP)
						pred.read_data = store[w.read_index * CAP + w.read_offset];
				end
				default: begin
					foreach (fill_len[i])
						fill_len[i] = 0;
					wr_ptr = 0;
					sd_ptr = 0;
					began_empty = 1'b0;
					bytes_left = 0;
					refusing = 1'b0;
				end
			endcase
			pending_rsp.push_back(pred);
		endfunction

		function void check_word(rsp_t got);
			rsp_t e;
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: status=%0d start=%0b idx=%0d len=%0d rd=%02h",
						got.status, got.start_valid, got.start_index, got.start_length,
						got.read_data);
				return;
			end
			e = pending_rsp.pop_front();
			if (got.status !== e.status || got.start_valid !== e.start_valid ||
			    got.start_index !== e.start_index || got.start_length !== e.start_length ||
			    got.read_data !== e.read_data) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: exp status=%0d start=%0b idx=%0d len=%0d rd=%02h",
						e.status, e.start_valid, e.start_index, e.start_length, e.read_data);
					$display("          got status=%0d start=%0b idx=%0d len=%0d rd=%02h",
						got.status, got.start_valid, got.start_index, got.start_length,
						got.read_data);
				end
			end
		endfunction
	endclass

	ring_scoreboard board = new();

	int burst_left;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic req_t byte_word(logic [7:0] d, logic f, logic [9:0] len, logic att);
		req_t w;
		w = req_t'($urandom);
		w.func = FN_BYTE;
		w.data = d;
		w.first = f;
		w.msg_len = len;
		w.attached = att;
		return w;
	endfunction

	function automatic req_t op_word(func_t f);
		req_t w;
		w = req_t'($urandom);
		w.func = f;
		return w;
	endfunction

	function automatic req_t read_word(int idx, int off);
		req_t w;
		w = op_word(FN_READ);
		w.read_index = 4'(idx);
		w.read_offset = 6'(off);
		return w;
	endfunction

	// only bytes already written are read back; otherwise aim past the end of a buffer
	function automatic req_t pick_read();
		int i;
		int idx;
		int off;
		if ($urandom_range(0, 9) != 0) begin
			for (i = 0; i < 16; i++) begin
				idx = $urandom_range(0, NB - 1);
				off = $urandom_range(0, CAP - 1);
				if (board.written[idx * CAP + off])
					return read_word(idx, off);
			end
		end
		return read_word($urandom_range(0, NB - 1), CAP);
	endfunction

	function automatic logic [9:0] pick_len();
		int r;
		r = $urandom_range(0, 199);
		if (r < 3)
			return 10'd0;
		else if (r < 7)
			return 10'($urandom_range(946, 1023));
		else if (r < 9)
			return 10'($urandom_range(700, 945));
		else if (r < 110)
			return 10'($urandom_range(1, 8));
		else if (r < 170)
			return 10'($urandom_range(9, 70));
		else
			return 10'($urandom_range(71, 250));
	endfunction

	task automatic send_word(req_t w);
		int r;
		int gap;
		@(negedge clk);
		req_valid = 1'b1;
		req = w;
		do @(posedge clk); while (!req_ready);
		board.note_word(w);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			r = $urandom_range(0, 9);
			if (r < 4)
				gap = 0;
			else if (r < 8)
				gap = $urandom_range(1, 3);
			else if (r < 9)
				gap = $urandom_range(4, 10);
			else
				gap = $urandom_range(11, 20);
			if (gap > 0) begin
				@(negedge clk);
				req_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(0, 40);
		end
	endtask

	task automatic directed_words();
		send_word(read_word(15, CAP));
		send_word(op_word(FN_DONE));
		send_word(byte_word(8'h11, 1'b0, 10'd5, 1'b1));
		send_word(byte_word(8'h22, 1'b1, 10'd4, 1'b0));
		send_word(byte_word(8'h33, 1'b0, 10'd4, 1'b1));
		send_word(byte_word(8'h44, 1'b1, 10'd0, 1'b1));
		send_word(byte_word(8'h55, 1'b1, 10'd1023, 1'b1));
		send_word(byte_word(8'hFF, 1'b1, 10'd1, 1'b1));
		send_word(byte_word(8'h00, 1'b1, 10'd3, 1'b1));
		send_word(byte_word(8'h01, 1'b0, 10'd3, 1'b1));
		send_word(byte_word(8'h02, 1'b0, 10'd3, 1'b1));
		send_word(byte_word(8'hA5, 1'b1, 10'd2, 1'b1));
		send_word(byte_word(8'hC3, 1'b1, 10'd7, 1'b1));
		send_word(byte_word(8'h5A, 1'b0, 10'd2, 1'b1));
		// next head is the open buffer: closed and started
		send_word(op_word(FN_DONE));
		send_word(read_word(0, 0));
		send_word(read_word(1, 4));
		send_word(op_word(FN_DONE));
		send_word(op_word(FN_BUS_RESET));
		send_word(byte_word(8'h80, 1'b1, 10'd1, 1'b1));
		send_word(byte_word(8'h7F, 1'b1, 10'd3, 1'b1));
		send_word(op_word(FN_DONE));
		// ring drains while the message is open
		send_word(op_word(FN_DONE));
		send_word(byte_word(8'h81, 1'b0, 10'd3, 1'b1));
		send_word(byte_word(8'h82, 1'b0, 10'd3, 1'b1));
		send_word(byte_word(8'h90, 1'b1, 10'd945, 1'b1));
	endtask

	task automatic random_words();
		int n;
		int r;
		req_t w;
		for (n = 0; n < RANDOM_WORDS; n++) begin
			r = $urandom_range(0, 99);
			if (board.bytes_left > 0) begin
				if (r < 86)
					w = byte_word(8'($urandom), 1'b0, 10'($urandom), 1'($urandom));
				else if (r < 92)
					w = op_word(FN_DONE);
				else if (r < 96)
					w = pick_read();
				else if (r < 99)
					w = byte_word(8'($urandom), 1'b1, pick_len(), 1'b1);
				else
					w = op_word(FN_BUS_RESET);
			end else begin
				if (r < 38)
					w = byte_word(8'($urandom), 1'b1, pick_len(), $urandom_range(0, 11) != 0);
				else if (r < 72)
					w = op_word(FN_DONE);
				else if (r < 88)
					w = pick_read();
				else if (r < 97)
					w = byte_word(8'($urandom), 1'b0, 10'($urandom), 1'($urandom));
				else
					w = op_word(FN_BUS_RESET);
			end
			send_word(w);
		end
	endtask

	// receiver: free-running, short frequent stalls, or rare long ones
	initial begin
		int mode;
		int stall_left;
		int cyc;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (cyc % 100 == 0)
				mode = $urandom_range(0, 2);
			cyc++;
			if (stall_left > 0) begin
				rsp_ready = 1'b0;
				stall_left--;
			end else begin
				rsp_ready = 1'b1;
				if (mode == 1 && $urandom_range(0, 2) == 0)
					stall_left = $urandom_range(1, 3);
				else if (mode == 2 && $urandom_range(0, 19) == 0)
					stall_left = $urandom_range(5, 25);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			board.check_word(rsp);
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		req_valid = 1'b0;
		req = '0;
		arst_n = 1'b0;
		burst_left = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		directed_words();
		random_words();
		@(negedge clk);
		req_valid = 1'b0;
		while (board.pending_rsp.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (board.mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
